>>> design/hmtp_pkg.sv
`timescale 1ns / 1ps

package hmtp_pkg;

	// Field widths of the item on each channel.
	localparam int COORD_W = 16;
	localparam int LINE_W  = 4;
	localparam int PLANE_W = 3;
	localparam int WORD_W  = 16;

	// Defaults for the map size and the number of planes.
	localparam int MAP_COLS_DEF   = 256;
	localparam int MAP_ROWS_DEF   = 128;
	localparam int NUM_PLANES_DEF = 6;

	// Hash constants.
	localparam logic [31:0] HASH_MUL_X = 32'h9e3779b9;
	localparam logic [31:0] HASH_MUL_Y = 32'h85ebca6b;
	localparam logic [31:0] HASH_SEED  = 32'h00001021;
	localparam logic [31:0] HASH_MUL_2 = 32'h7feb352d;

	// Border on lines 1 to 14: leftmost and rightmost pixel only.
	localparam logic [WORD_W-1:0] EDGE_SIDE = 16'h8001;
	localparam logic [LINE_W-1:0] LINE_TOP  = 4'd0;
	localparam logic [LINE_W-1:0] LINE_BOT  = 4'd15;

	// Color indices per variant.
	localparam logic [3:0] BG_COLOR   [4] = '{4'd3, 4'd8, 4'd10, 4'd12};
	localparam logic [3:0] INK_COLOR  [4] = '{4'd5, 4'd7, 4'd13, 4'd14};
	localparam logic [3:0] EDGE_COLOR [4] = '{4'd15, 4'd6, 4'd9, 4'd11};

	// Everything the drawing stage needs for one item.
	typedef struct packed {
		logic [3:0]        glyph;
		logic [1:0]        variant;
		logic [LINE_W-1:0] line;
		logic              plane_ok;
		logic [1:0]        plane_bit;
	} draw_req_t;

	// Row of the 5x7 hex font; bit 4 is the leftmost column.
	function automatic logic [4:0] font_row(input logic [3:0] glyph, input logic [2:0] row);
		logic [34:0] rows;
		begin
			unique case (glyph)
				4'h0: rows = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
				4'h1: rows = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
				4'h2: rows = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
				4'h3: rows = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
				4'h4: rows = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
				4'h5: rows = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
				4'h6: rows = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
				4'h7: rows = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
				4'h8: rows = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
				4'h9: rows = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
				4'ha: rows = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
				4'hb: rows = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
				4'hc: rows = {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
				4'hd: rows = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
				4'he: rows = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
				4'hf: rows = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
				default: rows = '0;
			endcase
			unique case (row)
				3'd0: font_row = rows[34:30];
				3'd1: font_row = rows[29:25];
				3'd2: font_row = rows[24:20];
				3'd3: font_row = rows[19:15];
				3'd4: font_row = rows[14:10];
				3'd5: font_row = rows[9:5];
				3'd6: font_row = rows[4:0];
				default: font_row = '0;
			endcase
		end
	endfunction

endpackage

>>> design/hmtp_req_if.sv
`timescale 1ns / 1ps

interface hmtp_req_if import hmtp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] tile_col;
	logic [COORD_W-1:0] tile_row;
	logic [LINE_W-1:0]  tile_line;
	logic [PLANE_W-1:0] plane;

	modport source (output valid, tile_col, tile_row, tile_line, plane, input ready);
	modport sink (input valid, tile_col, tile_row, tile_line, plane, output ready);
endinterface

>>> design/hmtp_rsp_if.sv
`timescale 1ns / 1ps

interface hmtp_rsp_if import hmtp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] plane_word;

	modport source (output valid, plane_word, input ready);
	modport sink (input valid, plane_word, output ready);
endinterface

>>> design/hmtp_tile_draw.sv
`timescale 1ns / 1ps

// Draws one line of a tile: border, corner markers, double-size glyph, then
// picks the requested bit of each pixel's color index.
module hmtp_tile_draw import hmtp_pkg::*; (
	input  draw_req_t         req,
	output logic [WORD_W-1:0] word
);

	logic [WORD_W-1:0] edge_m;
	logic [WORD_W-1:0] mark_raw;
	logic [WORD_W-1:0] mark_m;
	logic [WORD_W-1:0] gly_raw;
	logic [WORD_W-1:0] gly_m;
	logic [WORD_W-1:0] back_m;
	logic [4:0]        font_bits;
	logic [2:0]        font_sel;
	logic [LINE_W-1:0] line_m1;
	logic              big;
	logic [3:0]        bg_c;
	logic [3:0]        ink_c;
	logic [3:0]        edge_c;

	assign big = req.variant[0];
	assign line_m1 = req.line - LINE_W'(1);
	assign font_sel = line_m1[3:1];
	assign font_bits = font_row(req.glyph, font_sel);

	always_comb begin
		edge_m = (req.line == LINE_TOP || req.line == LINE_BOT) ? '1 : EDGE_SIDE;

		mark_raw = '0;
		// Top-left marker covers pixels 1..size on the first size lines.
		if (big) begin
			if (req.line < LINE_W'(3)) mark_raw = mark_raw | 16'h7000;
		end else begin
			if (req.line < LINE_W'(2)) mark_raw = mark_raw | 16'h6000;
		end
		// The bottom-right marker appears only on the upper two variants.
		if (req.variant[1]) begin
			if (big) begin
				if (req.line >= LINE_W'(12)) mark_raw = mark_raw | 16'h000e;
			end else begin
				if (req.line >= LINE_W'(13)) mark_raw = mark_raw | 16'h0006;
			end
		end
		mark_m = mark_raw & ~edge_m;

		gly_raw = '0;
		if (req.line != LINE_TOP && req.line != LINE_BOT) begin
			for (int g = 0; g < 5; g++) begin
				if (font_bits[4-g]) begin
					gly_raw[12-2*g] = 1'b1;
					gly_raw[11-2*g] = 1'b1;
				end
			end
		end
		gly_m = gly_raw & ~(edge_m | mark_m);
		back_m = ~(edge_m | mark_m | gly_m);

		bg_c   = BG_COLOR[req.variant];
		ink_c  = INK_COLOR[req.variant];
		edge_c = EDGE_COLOR[req.variant];

		word = '0;
		if (req.plane_ok) begin
			if (bg_c[req.plane_bit])   word = word | back_m;
			if (edge_c[req.plane_bit]) word = word | edge_m;
			if (ink_c[req.plane_bit])  word = word | mark_m | gly_m;
		end
	end

endmodule

>>> design/hashed_map_tile_plane_row_generator.sv
`timescale 1ns / 1ps

// Channel  Direction  Contents
// req      in         tile_col, tile_row, tile_line, plane
// rsp      out        plane_word
//
// Five register stages, s1 to s5, in turn carry an item from req to rsp, and one
// item can enter every cycle while rsp does not stall. The depth follows the four
// multiplications (wrap quotient, remainder, coordinate hash, second hash
// round), each followed by a register, with the drawing in the last stage.
// arst_n clears the valid bits of all stages; payload registers are not reset.
// A stall on rsp holds the output word while empty stages behind it fill up.
module hashed_map_tile_plane_row_generator import hmtp_pkg::*; #(
	parameter int MAP_COLS   = MAP_COLS_DEF,
	parameter int MAP_ROWS   = MAP_ROWS_DEF,
	parameter int NUM_PLANES = NUM_PLANES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hmtp_req_if.sink    req,
	hmtp_rsp_if.source  rsp
);

	// Wrapped coordinate widths.
	localparam int XW = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
	localparam int YW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

	// Floor reciprocals scaled by 2^32. For inputs below 2^16 the quotient
	// estimate is at most one short, so one conditional subtract fixes it.
	localparam logic [32:0] RECIP_COLS = 33'((64'd1 << 32) / MAP_COLS);
	localparam logic [32:0] RECIP_ROWS = 33'((64'd1 << 32) / MAP_ROWS);
	localparam logic [16:0] COLS_17    = 17'(MAP_COLS);
	localparam logic [16:0] ROWS_17    = 17'(MAP_ROWS);
	localparam logic [3:0]  PCOUNT_4   = 4'(NUM_PLANES);

	// Handshake per stage.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;

	assign ready_s5 = !valid_s5 || rsp.ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign req.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= req.valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: quotient estimates for the wrap, and plane qualification.
	// Color indices are four bits wide, so only planes 0 to 3 can be nonzero.
	logic [48:0]        qx_prod, qy_prod;
	logic [COORD_W-1:0] col_s1, row_s1, qx_s1, qy_s1;
	logic [LINE_W-1:0]  line_s1;
	logic               pok_s1;
	logic [1:0]         pbit_s1;

	assign qx_prod = 49'(req.tile_col) * 49'(RECIP_COLS);
	assign qy_prod = 49'(req.tile_row) * 49'(RECIP_ROWS);

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			col_s1  <= req.tile_col;
			row_s1  <= req.tile_row;
			qx_s1   <= qx_prod[47:32];
			qy_s1   <= qy_prod[47:32];
			line_s1 <= req.tile_line;
			pok_s1  <= ({1'b0, req.plane} < PCOUNT_4) && !req.plane[2];
			pbit_s1 <= req.plane[1:0];
		end
	end

	// Stage 2: remainder, corrected by one subtract.
	logic [31:0]       mx_prod, my_prod;
	logic [16:0]       rx_raw, ry_raw, rx, ry;
	logic [XW-1:0]     x_s2;
	logic [YW-1:0]     y_s2;
	logic [LINE_W-1:0] line_s2;
	logic              pok_s2;
	logic [1:0]        pbit_s2;

	assign mx_prod = 32'(qx_s1) * 32'(COLS_17);
	assign my_prod = 32'(qy_s1) * 32'(ROWS_17);
	assign rx_raw  = 17'(col_s1) - mx_prod[16:0];
	assign ry_raw  = 17'(row_s1) - my_prod[16:0];
	assign rx      = (rx_raw >= COLS_17) ? rx_raw - COLS_17 : rx_raw;
	assign ry      = (ry_raw >= ROWS_17) ? ry_raw - ROWS_17 : ry_raw;

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			x_s2    <= rx[XW-1:0];
			y_s2    <= ry[YW-1:0];
			line_s2 <= line_s1;
			pok_s2  <= pok_s1;
			pbit_s2 <= pbit_s1;
		end
	end

	// Stage 3: first hash round, both products in parallel, then fold.
	logic [31:0]       hx, hy, h0;
	logic [31:0]       h_s3;
	logic [LINE_W-1:0] line_s3;
	logic              pok_s3;
	logic [1:0]        pbit_s3;

	assign hx = 32'(x_s2) * HASH_MUL_X;
	assign hy = 32'(y_s2) * HASH_MUL_Y;
	assign h0 = hx ^ hy ^ HASH_SEED;

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			h_s3    <= h0 ^ (h0 >> 16);
			line_s3 <= line_s2;
			pok_s3  <= pok_s2;
			pbit_s3 <= pbit_s2;
		end
	end

	// Stage 4: second hash multiply.
	logic [31:0]       h_s4;
	logic [LINE_W-1:0] line_s4;
	logic              pok_s4;
	logic [1:0]        pbit_s4;

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			h_s4    <= h_s3 * HASH_MUL_2;
			line_s4 <= line_s3;
			pok_s4  <= pok_s3;
			pbit_s4 <= pbit_s3;
		end
	end

	// Stage 5: final fold (only the six low bits are used), then draw.
	logic [5:0]        h_low;
	draw_req_t         draw_req;
	logic [WORD_W-1:0] draw_word;
	logic [WORD_W-1:0] word_s5;
	logic [LINE_W-1:0] line_s5;
	logic              pok_s5;

	assign h_low = h_s4[5:0] ^ h_s4[20:15];

	always_comb begin
		draw_req.glyph     = h_low[3:0];
		draw_req.variant   = h_low[5:4];
		draw_req.line      = line_s4;
		draw_req.plane_ok  = pok_s4;
		draw_req.plane_bit = pbit_s4;
	end

	hmtp_tile_draw u_draw (
		.req  (draw_req),
		.word (draw_word)
	);

	always_ff @(posedge clk) begin
		if (ready_s5) begin
			word_s5 <= draw_word;
			line_s5 <= line_s4;
			pok_s5  <= pok_s4;
		end
	end

	assign rsp.valid      = valid_s5;
	assign rsp.plane_word = word_s5;

	// A plane with no color bit must come out blank.
	a_plane_off_blank: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !pok_s5 |-> word_s5 == '0)
		else $error("disabled plane produced a nonzero word");

	// Top and bottom lines are pure border: all pixels share one color.
	a_edge_line_uniform: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && (line_s5 == LINE_TOP || line_s5 == LINE_BOT) |->
		(word_s5 == '0 || word_s5 == '1))
		else $error("border line is not uniform");

	// On inner lines the two outermost pixels are both border.
	a_side_border_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && line_s5 != LINE_TOP && line_s5 != LINE_BOT |->
		word_s5[WORD_W-1] == word_s5[0])
		else $error("left and right border pixels differ");

	// An output only becomes valid by moving an item out of stage four.
	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s5) |-> $past(valid_s4))
		else $error("output valid without an item in stage four");

endmodule
